// File: hw/rtl/ps2mpt_pkg.sv
// Shared types and constants for the PS/2 mouse packet tracker.
package ps2mpt_pkg;

  // Configuration register byte addresses
  localparam logic [2:0] ADDR_MAX_X = 3'd0;
  localparam logic [2:0] ADDR_MAX_Y = 3'd4;

  localparam logic [11:0] RST_MAX_X = 12'd624;
  localparam logic [11:0] RST_MAX_Y = 12'd464;
  localparam logic [15:0] RST_CUR_X = 16'd320;
  localparam logic [15:0] RST_CUR_Y = 16'd200;

  // Header byte bit positions
  localparam int unsigned HDR_SYNC_IDX = 3;
  localparam int unsigned HDR_LEFT_IDX = 0;

  typedef enum logic [2:0] {
    PH_HDR = 3'b001,
    PH_DX  = 3'b010,
    PH_DY  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [11:0] max_x;
    logic [11:0] max_y;
  } limits_t;

endpackage

// File: hw/rtl/ps2mpt_regs.sv
// APB-style register file holding the cursor clamp limits.
module ps2mpt_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output ps2mpt_pkg::limits_t  limits
);

  ps2mpt_pkg::limits_t lim_r, lim_nxt;
  logic                wr_en;

  assign wr_en = psel && penable && pwrite;

  always_comb begin
    lim_nxt = lim_r;
    if (wr_en) begin
      if (paddr == ps2mpt_pkg::ADDR_MAX_X) begin
        lim_nxt.max_x = pwdata[11:0];
      end else if (paddr == ps2mpt_pkg::ADDR_MAX_Y) begin
        lim_nxt.max_y = pwdata[11:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r.max_x <= ps2mpt_pkg::RST_MAX_X;
      lim_r.max_y <= ps2mpt_pkg::RST_MAX_Y;
    end else begin
      lim_r <= lim_nxt;
    end
  end

  always_comb begin
    if (paddr == ps2mpt_pkg::ADDR_MAX_X) begin
      prdata = {20'd0, lim_r.max_x};
    end else if (paddr == ps2mpt_pkg::ADDR_MAX_Y) begin
      prdata = {20'd0, lim_r.max_y};
    end else begin
      prdata = 32'd0;
    end
  end

  assign limits = lim_r;

endmodule

// File: hw/rtl/ps2_mouse_packet_tracker_unit.sv
// Top level of the PS/2 mouse packet tracker: packet assembly and cursor update.
//
// Usage: feed raw controller bytes on the in_ stream, with in_tuser set when
// the byte came from the auxiliary (mouse) port. Bytes are grouped into
// three-byte packets; a header byte must come from the aux port and carry
// bit 3, otherwise it is dropped while the block hunts for sync. Each
// completed packet produces one request on the out_ stream carrying the
// clamped cursor position and the left button state.
// Path: a packet's third byte is accepted into the input register, then its
// result is loaded into the result register. Throughput: one byte per cycle
// unless a packet-completing byte waits on a held result, limited by the single
// cursor update path between the two registers. The cfg_ port sets max_x
// (address 0) and max_y (address 4); write it only while no bytes are in flight.
// Reset: cursor returns to (320, 200) masked to COORD_BITS, limits to
// (624, 464), packet phase to header hunt.
// Stall: while out_tready is low a waiting result is held; bytes that do not
// complete a packet keep flowing, and a packet-completing byte waits in the
// input register, which then drops in_tready.
module ps2_mouse_packet_tracker_unit #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [7:0] data_byte
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // in_tuser: [0] from_aux
  input  logic [0:0]  in_tuser,
  // out_tdata: [11:0] pos_x, [23:12] pos_y, [24] left_button, [31:25] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned SW = COORD_BITS + 2;
  localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
  localparam logic [COORD_BITS-1:0] RST_X = COORD_BITS'(ps2mpt_pkg::RST_CUR_X);
  localparam logic [COORD_BITS-1:0] RST_Y = COORD_BITS'(ps2mpt_pkg::RST_CUR_Y);

  ps2mpt_pkg::limits_t limits;

  ps2mpt_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .limits  (limits)
  );

  assign cfg_pready = 1'b1;

  // Input register
  logic       in_v_r, in_v_nxt;
  logic [7:0] in_byte_r;
  logic       in_aux_r;

  // Packet state
  ps2mpt_pkg::phase_t  phase_r, phase_nxt;
  logic                hdr_left_r, hdr_left_nxt;
  logic [7:0]          dx_r, dx_nxt;
  logic [COORD_BITS-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;

  // Result register
  logic        out_v_r, out_v_nxt;
  logic [11:0] pos_x_r, pos_y_r;
  logic        left_r;

  logic                  emit, hdr_ok, adv, out_free;
  logic [COORD_BITS-1:0] lim_x, lim_y, clx, cly;
  logic signed [SW-1:0]  nx, ny;

  // Clamp limit is the smaller of the register and the coordinate range
  always_comb begin
    lim_x = (17'(limits.max_x) > 17'(COORD_MAX)) ? COORD_MAX : COORD_BITS'(limits.max_x);
    lim_y = (17'(limits.max_y) > 17'(COORD_MAX)) ? COORD_MAX : COORD_BITS'(limits.max_y);
  end

  assign nx = $signed({2'b00, cur_x_r}) + SW'($signed(dx_r));
  assign ny = $signed({2'b00, cur_y_r}) - SW'($signed(in_byte_r));

  always_comb begin
    if (nx < 0) begin
      clx = '0;
    end else if ($unsigned(nx) > SW'(lim_x)) begin
      clx = lim_x;
    end else begin
      clx = COORD_BITS'(nx);
    end
    if (ny < 0) begin
      cly = '0;
    end else if ($unsigned(ny) > SW'(lim_y)) begin
      cly = lim_y;
    end else begin
      cly = COORD_BITS'(ny);
    end
  end

  assign emit     = (phase_r == ps2mpt_pkg::PH_DY);
  assign hdr_ok   = in_aux_r && in_byte_r[ps2mpt_pkg::HDR_SYNC_IDX];
  assign out_free = !out_v_r || out_tready;
  // Only a packet-completing byte needs room in the result register
  assign adv      = in_v_r && (!emit || out_free);
  assign in_tready = !in_v_r || adv;

  always_comb begin
    phase_nxt    = phase_r;
    hdr_left_nxt = hdr_left_r;
    dx_nxt       = dx_r;
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    if (adv) begin
      unique case (phase_r)
        ps2mpt_pkg::PH_DX: begin
          dx_nxt    = in_byte_r;
          phase_nxt = ps2mpt_pkg::PH_DY;
        end
        ps2mpt_pkg::PH_DY: begin
          cur_x_nxt = clx;
          cur_y_nxt = cly;
          phase_nxt = ps2mpt_pkg::PH_HDR;
        end
        default: begin
          // Hunt for sync: drop anything that is not a valid header
          if (hdr_ok) begin
            hdr_left_nxt = in_byte_r[ps2mpt_pkg::HDR_LEFT_IDX];
            phase_nxt    = ps2mpt_pkg::PH_DX;
          end else begin
            phase_nxt    = ps2mpt_pkg::PH_HDR;
          end
        end
      endcase
    end
  end

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_tvalid && in_tready) begin
      in_v_nxt = 1'b1;
    end else if (adv) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (adv && emit) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      phase_r    <= ps2mpt_pkg::PH_HDR;
      hdr_left_r <= 1'b0;
      dx_r       <= 8'd0;
      cur_x_r    <= RST_X;
      cur_y_r    <= RST_Y;
    end else begin
      in_v_r     <= in_v_nxt;
      out_v_r    <= out_v_nxt;
      phase_r    <= phase_nxt;
      hdr_left_r <= hdr_left_nxt;
      dx_r       <= dx_nxt;
      cur_x_r    <= cur_x_nxt;
      cur_y_r    <= cur_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_aux_r  <= in_tuser[0];
    end
    if (adv && emit) begin
      pos_x_r <= 12'(clx);
      pos_y_r <= 12'(cly);
      left_r  <= hdr_left_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, left_r, pos_y_r, pos_x_r};

  a_emit_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv && emit |=> out_v_r && phase_r == ps2mpt_pkg::PH_HDR)
    else $error("completed packet did not load the result register");

  a_header_sync: assert property (@(posedge clk) disable iff (!rst_n)
    adv && phase_r == ps2mpt_pkg::PH_HDR && hdr_ok |=> phase_r == ps2mpt_pkg::PH_DX)
    else $error("valid header did not advance the packet phase");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_v_r && emit && out_v_r && !out_tready)
    else $error("input stalled without a blocked result");

  a_clamp_x: assert property (@(posedge clk) disable iff (!rst_n)
    adv && emit |=> cur_x_r <= $past(lim_x) && cur_y_r <= $past(lim_y))
    else $error("cursor left the clamp range after a packet");

endmodule
